[hdl/ffrp_pkg.sv]
// Shared widths, result codes and controller/datapath interface types.
`default_nettype none

package ffrp_pkg;

    // Fixed field widths of the stream and configuration ports.
    localparam int DIM_W     = 13;
    localparam int POS_W     = 12;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;
    localparam int CFG_IDX_W = 8;

    // Reset value of both atlas dimension registers.
    localparam logic [DIM_W-1:0] ATLAS_DIM_RESET = DIM_W'(256);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_HEIGHT = CFG_IDX_W'(1);

    // Request kinds.
    localparam logic KIND_CLEAR = 1'b0;
    localparam logic KIND_PLACE = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_PLACED     = 2'd0,
        ST_NO_FIT     = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_CLEARED    = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_req;
        logic    clear_cnt;
        logic    init_row;
        logic    init_col;
        logic    next_row;
        logic    start_scan;
        logic    next_idx;
        logic    jump_u;
        logic    place;
        logic    load_out;
        t_status res_code;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic kind;
        logic full;
        logic size_bad;
        logic row_over;
        logic col_over;
        logic cnt_zero;
        logic hit;
        logic last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

[hdl/ffrp_datapath.sv]
// Datapath: config registers, request latch, scan counters, rectangle table, result register.
`default_nettype none

module ffrp_datapath
    import ffrp_pkg::*;
#(
    parameter int MAX_RECTS  = 64,
    parameter int COORD_BITS = 12
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // Configuration writes
    input  wire                  i_cfg_valid,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [DIM_W-1:0]      i_cfg_data,
    // Request fields
    input  wire                  i_kind,
    input  wire [DIM_W-1:0]      i_rect_width,
    input  wire [DIM_W-1:0]      i_rect_height,
    // Result stream
    input  wire                  i_m_tready,
    output logic                 o_m_tvalid,
    output t_status              o_status,
    output logic [POS_W-1:0]     o_pos_u,
    output logic [POS_W-1:0]     o_pos_v,
    // Controller link
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat
);

    // Coordinate width holds any dimension or corner; sums get one more bit.
    localparam int XW    = (COORD_BITS + 1 > DIM_W) ? COORD_BITS + 1 : DIM_W;
    localparam int SW    = XW + 1;
    localparam int EW    = 4 * XW;
    localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CNT_W = $clog2(MAX_RECTS + 1);
    localparam logic [XW-1:0]    LIM      = XW'(1) << COORD_BITS;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_RECTS);

    logic [DIM_W-1:0] r_cfg_aw, r_cfg_ah;
    logic             r_kind;
    logic [XW-1:0]    r_w, r_h, r_aw, r_ah;
    logic [XW-1:0]    r_u, r_v;
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_count;
    logic [EW-1:0]    r_mem [MAX_RECTS];
    logic [EW-1:0]    r_rd_data;
    logic             r_o_valid;
    t_status          r_o_status;
    logic [POS_W-1:0] r_o_u, r_o_v;

    logic [XW-1:0]    cfg_aw_x, cfg_ah_x, n_aw, n_ah;
    logic [XW-1:0]    ent_u, ent_v, ent_w, ent_h;
    logic [SW-1:0]    u_end, v_end, ent_u_end, ent_v_end;

    // Atlas dimension registers, written at any transfer on the config channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_aw <= ATLAS_DIM_RESET;
            r_cfg_ah <= ATLAS_DIM_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_ATLAS_WIDTH) begin
                r_cfg_aw <= i_cfg_data;
            end
            if (i_cfg_index == REG_ATLAS_HEIGHT) begin
                r_cfg_ah <= i_cfg_data;
            end
        end
    end

    // Atlas dimensions are limited to the coordinate range.
    always_comb begin
        cfg_aw_x = XW'(r_cfg_aw);
        cfg_ah_x = XW'(r_cfg_ah);
        n_aw     = (cfg_aw_x > LIM) ? LIM : cfg_aw_x;
        n_ah     = (cfg_ah_x > LIM) ? LIM : cfg_ah_x;
    end

    // Request latch and scan position.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_kind <= i_kind;
            r_w    <= XW'(i_rect_width);
            r_h    <= XW'(i_rect_height);
            r_aw   <= n_aw;
            r_ah   <= n_ah;
        end
        if (i_cmd.init_row) begin
            r_v <= '0;
        end else if (i_cmd.next_row) begin
            r_v <= r_v + XW'(1);
        end
        if (i_cmd.init_col) begin
            r_u <= '0;
        end else if (i_cmd.jump_u) begin
            r_u <= ent_u_end[XW-1:0];
        end
        if (i_cmd.start_scan) begin
            r_idx <= '0;
        end else if (i_cmd.next_idx) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // Fill count of the table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear_cnt) begin
            r_count <= '0;
        end else if (i_cmd.place) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // Rectangle table: one write port at the fill count, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.place) begin
            r_mem[r_count[IDX_W-1:0]] <= {r_h, r_w, r_v, r_u};
        end
        r_rd_data <= r_mem[r_idx];
    end

    // Overlap test of the candidate against the entry just read.
    always_comb begin
        {ent_h, ent_w, ent_v, ent_u} = r_rd_data;
        u_end     = SW'(r_u) + SW'(r_w);
        v_end     = SW'(r_v) + SW'(r_h);
        ent_u_end = SW'(ent_u) + SW'(ent_w);
        ent_v_end = SW'(ent_v) + SW'(ent_h);
    end

    always_comb begin
        o_stat.kind     = r_kind;
        o_stat.full     = (r_count == CNT_FULL);
        o_stat.size_bad = (r_w == '0) || (r_h == '0) || (r_w > r_aw) || (r_h > r_ah);
        o_stat.row_over = (v_end > SW'(r_ah));
        o_stat.col_over = (u_end > SW'(r_aw));
        o_stat.cnt_zero = (r_count == '0);
        o_stat.hit      = (SW'(r_v) < ent_v_end) && (v_end > SW'(ent_v)) &&
                          (SW'(r_u) < ent_u_end) && (u_end > SW'(ent_u));
        o_stat.last     = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
        o_stat.out_free = !r_o_valid || i_m_tready;
    end

    // Result register; holds until the receiver takes the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_status <= i_cmd.res_code;
            if (i_cmd.res_code == ST_PLACED) begin
                r_o_u <= r_u[POS_W-1:0];
                r_o_v <= r_v[POS_W-1:0];
            end else begin
                r_o_u <= '0;
                r_o_v <= '0;
            end
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_status   = r_o_status;
    assign o_pos_u    = r_o_u;
    assign o_pos_v    = r_o_v;

endmodule

`default_nettype wire

[hdl/ffrp_controller.sv]
// Controller: sequences the decision, the raster scan and the table compares of one request.
`default_nettype none

module ffrp_controller
    import ffrp_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_s_tvalid,
    output logic      o_s_tready,
    input  t_dp_stat  i_stat,
    output t_dp_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_ROW,
        S_COL,
        S_READ,
        S_CMP,
        S_PLACE,
        S_RESULT
    } t_state;

    t_state  r_state, n_state;
    t_status r_code, n_code;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        o_cmd.res_code = r_code;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.kind == KIND_CLEAR) begin
                    o_cmd.clear_cnt = 1'b1;
                    n_code          = ST_CLEARED;
                    n_state         = S_RESULT;
                end else if (i_stat.full) begin
                    n_code  = ST_TABLE_FULL;
                    n_state = S_RESULT;
                end else if (i_stat.size_bad) begin
                    n_code  = ST_NO_FIT;
                    n_state = S_RESULT;
                end else begin
                    o_cmd.init_row = 1'b1;
                    n_state        = S_ROW;
                end
            end
            S_ROW: begin
                // The rectangle no longer fits below this row: no room anywhere.
                if (i_stat.row_over) begin
                    n_code  = ST_NO_FIT;
                    n_state = S_RESULT;
                end else begin
                    o_cmd.init_col = 1'b1;
                    n_state        = S_COL;
                end
            end
            S_COL: begin
                if (i_stat.col_over) begin
                    o_cmd.next_row = 1'b1;
                    n_state        = S_ROW;
                end else if (i_stat.cnt_zero) begin
                    n_state = S_PLACE;
                end else begin
                    o_cmd.start_scan = 1'b1;
                    n_state          = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                // A collision moves the candidate just past the colliding entry.
                if (i_stat.hit) begin
                    o_cmd.jump_u = 1'b1;
                    n_state      = S_COL;
                end else if (i_stat.last) begin
                    n_state = S_PLACE;
                end else begin
                    o_cmd.next_idx = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_code      = ST_PLACED;
                n_state     = S_RESULT;
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and result code registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_NO_FIT;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

`default_nettype wire

[hdl/first_fit_rectangle_placer.sv]
// Top level of the first-fit rectangle placer: stream ports and module wiring.
//
// Usage: configuration writes set atlas_width (index 0) and atlas_height
// (index 1); they are accepted in every cycle and must be made while idle.
// A request arrives on the slave stream: tuser is the kind (0 clear, 1 place),
// tdata carries the rectangle size. Each request gives exactly one result on
// the master stream: tuser is the status, tdata the placed corner.
// Requests are handled one at a time. A clear, a full table or a bad size
// goes straight to the result; a placement steps through rows, the corners
// of each row and, per corner, compares with the stored entries, each compare
// a table read and then a test; a no-fit scan ends with a final row check.
// The time taken grows with the stored rectangles and the atlas height.
// The result sits in an output register until taken, and the next request is
// accepted while it waits; a further result waits in the controller until the
// register is free, so nothing is lost when the receiver stalls.
// Reset empties the table, sets both atlas dimensions to 256 and clears all
// pending transfers.
`default_nettype none

module first_fit_rectangle_placer
    import ffrp_pkg::*;
#(
    parameter int MAX_RECTS  = 64,
    parameter int COORD_BITS = 12
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // Configuration write channel
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [DIM_W-1:0]      i_cfg_data,
    // Request stream
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire [S_TDATA_W-1:0]  s_axis_tdata,   // rect_width[12:0], rect_height[25:13], zero
    input  wire                  s_axis_tuser,   // kind
    // Result stream
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // pos_u[11:0], pos_v[23:12]
    output logic [STATUS_W-1:0]  m_axis_tuser    // status
);

    t_dp_cmd          cmd;
    t_dp_stat         stat;
    t_status          status;
    logic [POS_W-1:0] pos_u, pos_v;

    ffrp_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ffrp_datapath #(
        .MAX_RECTS  (MAX_RECTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_kind        (s_axis_tuser),
        .i_rect_width  (s_axis_tdata[DIM_W-1:0]),
        .i_rect_height (s_axis_tdata[2*DIM_W-1:DIM_W]),
        .i_m_tready    (m_axis_tready),
        .o_m_tvalid    (m_axis_tvalid),
        .o_status      (status),
        .o_pos_u       (pos_u),
        .o_pos_v       (pos_v),
        .i_cmd         (cmd),
        .o_stat        (stat)
    );

    // Configuration writes never stall.
    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {pos_v, pos_u};
    assign m_axis_tuser = status;

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the first-fit rectangle placer with a placement predictor.
`timescale 1ns / 100ps

module tb;
    import ffrp_pkg::*;

    localparam int TABLE_DEPTH  = 64;
    localparam int COORD_LIMIT  = 4096;
    localparam int PHASE_ITEMS  = 14;
    localparam int SETTLE_CYCLES = 20;

    // One result as it appears on the result stream.
    typedef struct packed {
        t_status          status;
        logic [POS_W-1:0] pos_u;
        logic [POS_W-1:0] pos_v;
    } t_placement;

    // One row of the directed table; typed rows carry their result, the rest use the predictor.
    typedef struct packed {
        logic             set_atlas;
        logic [DIM_W-1:0] atlas_w;
        logic [DIM_W-1:0] atlas_h;
        logic             kind;
        logic [DIM_W-1:0] rect_w;
        logic [DIM_W-1:0] rect_h;
        logic [7:0]       copies;
        logic             typed;
        t_status          status;
        logic [POS_W-1:0] pos_u;
        logic [POS_W-1:0] pos_v;
    } t_step_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [DIM_W-1:0]      i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;

    // Typed result that travels alongside the request being offered.
    logic       req_has_answer;
    t_placement req_answer;

    int send_gap_pct   = 18;
    int recv_stall_pct = 71;
    int mismatches     = 0;

    // Predictor state: atlas registers and the table of placed rectangles.
    logic [DIM_W-1:0] atlas_w_cfg = ATLAS_DIM_RESET;
    logic [DIM_W-1:0] atlas_h_cfg = ATLAS_DIM_RESET;
    int               tab_u [TABLE_DEPTH];
    int               tab_v [TABLE_DEPTH];
    int               tab_w [TABLE_DEPTH];
    int               tab_h [TABLE_DEPTH];
    int               placed_n = 0;

    t_placement placements_due [$];

    // atl  aw    ah    kind        w     h     n   typed status         u     v
    t_step_row directed_steps [30] = '{
        '{0, 0,    0,    KIND_CLEAR, 0,    0,    1,  1, ST_CLEARED,    0,    0},
        '{0, 0,    0,    KIND_PLACE, 256,  256,  1,  1, ST_PLACED,     0,    0},
        '{0, 0,    0,    KIND_PLACE, 1,    1,    1,  1, ST_NO_FIT,     0,    0},
        '{0, 0,    0,    KIND_CLEAR, 8191, 8191, 1,  1, ST_CLEARED,    0,    0},
        '{0, 0,    0,    KIND_PLACE, 257,  1,    1,  1, ST_NO_FIT,     0,    0},
        '{0, 0,    0,    KIND_PLACE, 1,    257,  1,  1, ST_NO_FIT,     0,    0},
        '{0, 0,    0,    KIND_PLACE, 0,    5,    1,  1, ST_NO_FIT,     0,    0},
        '{0, 0,    0,    KIND_PLACE, 5,    0,    1,  1, ST_NO_FIT,     0,    0},
        '{0, 0,    0,    KIND_PLACE, 8191, 8191, 1,  1, ST_NO_FIT,     0,    0},
        '{0, 0,    0,    KIND_PLACE, 100,  30,   3,  0, ST_PLACED,     0,    0},
        '{1, 0,    0,    KIND_PLACE, 1,    1,    1,  1, ST_NO_FIT,     0,    0},
        '{1, 0,    256,  KIND_PLACE, 1,    1,    1,  1, ST_NO_FIT,     0,    0},
        '{1, 1,    1,    KIND_CLEAR, 0,    0,    1,  1, ST_CLEARED,    0,    0},
        '{0, 0,    0,    KIND_PLACE, 1,    1,    1,  1, ST_PLACED,     0,    0},
        '{0, 0,    0,    KIND_PLACE, 1,    1,    1,  1, ST_NO_FIT,     0,    0},
        '{1, 8191, 8191, KIND_CLEAR, 0,    0,    1,  1, ST_CLEARED,    0,    0},
        '{0, 0,    0,    KIND_PLACE, 4096, 4096, 1,  1, ST_PLACED,     0,    0},
        '{0, 0,    0,    KIND_CLEAR, 0,    0,    1,  1, ST_CLEARED,    0,    0},
        '{0, 0,    0,    KIND_PLACE, 4095, 4096, 1,  1, ST_PLACED,     0,    0},
        '{0, 0,    0,    KIND_PLACE, 1,    4096, 1,  1, ST_PLACED,     4095, 0},
        '{0, 0,    0,    KIND_CLEAR, 0,    0,    1,  1, ST_CLEARED,    0,    0},
        '{0, 0,    0,    KIND_PLACE, 4096, 4095, 1,  1, ST_PLACED,     0,    0},
        '{0, 0,    0,    KIND_PLACE, 4096, 1,    1,  0, ST_PLACED,     0,    0},
        '{1, 8,    8,    KIND_CLEAR, 0,    0,    1,  1, ST_CLEARED,    0,    0},
        '{0, 0,    0,    KIND_PLACE, 1,    1,    64, 0, ST_PLACED,     0,    0},
        '{0, 0,    0,    KIND_PLACE, 1,    1,    1,  1, ST_TABLE_FULL, 0,    0},
        '{0, 0,    0,    KIND_PLACE, 0,    0,    1,  1, ST_TABLE_FULL, 0,    0},
        '{0, 0,    0,    KIND_CLEAR, 0,    0,    1,  1, ST_CLEARED,    0,    0},
        '{0, 0,    0,    KIND_PLACE, 3,    2,    5,  0, ST_PLACED,     0,    0},
        '{0, 0,    0,    KIND_PLACE, 8,    8,    1,  0, ST_PLACED,     0,    0}
    };

    first_fit_rectangle_placer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // The receiver stalls at the rate set for the current phase.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Scans corners row by row, left to right within a row, and stores the first free spot.
    function automatic void predict_placement(input logic kind, input logic [DIM_W-1:0] req_w,
                                              input logic [DIM_W-1:0] req_h,
                                              output t_placement res);
        int aw;
        int ah;
        int rw;
        int rh;
        int cu;
        int cv;
        int hit;
        aw  = (atlas_w_cfg > COORD_LIMIT) ? COORD_LIMIT : atlas_w_cfg;
        ah  = (atlas_h_cfg > COORD_LIMIT) ? COORD_LIMIT : atlas_h_cfg;
        rw  = req_w;
        rh  = req_h;
        res = '{ST_NO_FIT, '0, '0};
        if (kind == KIND_CLEAR) begin
            placed_n   = 0;
            res.status = ST_CLEARED;
            return;
        end
        // A full table wins over every size check.
        if (placed_n >= TABLE_DEPTH) begin
            res.status = ST_TABLE_FULL;
            return;
        end
        if (rw == 0 || rh == 0 || rw > aw || rh > ah) begin
            return;
        end
        for (cv = 0; cv + rh <= ah; cv++) begin
            cu = 0;
            while (cu + rw <= aw) begin
                hit = placed_n;
                for (int i = 0; i < placed_n; i++) begin
                    if (cv < tab_v[i] + tab_h[i] && cv + rh > tab_v[i] &&
                        cu < tab_u[i] + tab_w[i] && cu + rw > tab_u[i]) begin
                        hit = i;
                        break;
                    end
                end
                if (hit == placed_n) begin
                    tab_u[placed_n] = cu;
                    tab_v[placed_n] = cv;
                    tab_w[placed_n] = rw;
                    tab_h[placed_n] = rh;
                    placed_n++;
                    res.status = ST_PLACED;
                    res.pos_u  = POS_W'(cu);
                    res.pos_v  = POS_W'(cv);
                    return;
                end
                // Skip the columns covered by the rectangle in the way.
                cu = tab_u[hit] + tab_w[hit];
            end
        end
    endfunction

    // Tracks register writes and requests, and checks each result against the oldest one due.
    always @(posedge i_clk) begin : scoreboard
        t_placement predicted;
        t_placement want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_ATLAS_WIDTH:  atlas_w_cfg = i_cfg_data;
                    REG_ATLAS_HEIGHT: atlas_h_cfg = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_placement(s_axis_tuser, s_axis_tdata[DIM_W-1:0],
                                  s_axis_tdata[2*DIM_W-1:DIM_W], predicted);
                placements_due.push_back(req_has_answer ? req_answer : predicted);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (placements_due.size() == 0) begin
                    $error("result with none due: status %0d, tdata %0h",
                           m_axis_tuser, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = placements_due.pop_front();
                    if (m_axis_tuser !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
                        mismatches++;
                    end
                    if (m_axis_tdata[POS_W-1:0] !== want.pos_u) begin
                        $error("pos_u: expected %0d, actual %0d",
                               want.pos_u, m_axis_tdata[POS_W-1:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[2*POS_W-1:POS_W] !== want.pos_v) begin
                        $error("pos_v: expected %0d, actual %0d",
                               want.pos_v, m_axis_tdata[2*POS_W-1:POS_W]);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Offers one request after a random gap and holds it until the transfer.
    task automatic send_request(input logic kind, input logic [DIM_W-1:0] req_w,
                                input logic [DIM_W-1:0] req_h, input logic has_answer,
                                input t_placement answer);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid  <= 1'b1;
        s_axis_tuser   <= kind;
        s_axis_tdata   <= S_TDATA_W'({req_h, req_w});
        req_has_answer <= has_answer;
        req_answer     <= answer;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stops sending and waits until every result due has been taken.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (placements_due.size() != 0) @(posedge i_clk);
    endtask

    // Writes both atlas registers back to back.
    task automatic write_atlas(input logic [DIM_W-1:0] aw, input logic [DIM_W-1:0] ah);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_ATLAS_WIDTH;
        i_cfg_data  <= aw;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= REG_ATLAS_HEIGHT;
        i_cfg_data  <= ah;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        t_step_row        row;
        t_placement       answer;
        logic             kind;
        logic [DIM_W-1:0] rw;
        logic [DIM_W-1:0] rh;
        int               aw;
        int               ah;
        int               sel;
        int               gap_pcts [3];
        int               stall_pcts [3];
        gap_pcts       = '{18, 71, 0};
        stall_pcts     = '{71, 18, 0};
        i_rst_n        <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_data     <= '0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tuser   <= KIND_CLEAR;
        req_has_answer <= 1'b0;
        req_answer     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: extremes, every special case, and a table filled to the brim.
        foreach (directed_steps[r]) begin
            row = directed_steps[r];
            if (row.set_atlas) begin
                wait_for_results();
                write_atlas(row.atlas_w, row.atlas_h);
            end
            answer = '{row.status, row.pos_u, row.pos_v};
            for (int n = 0; n < row.copies; n++) begin
                send_request(row.kind, row.rect_w, row.rect_h, row.typed, answer);
            end
        end

        // Random traffic in three phases of set gap and stall rates, each on a fresh small atlas.
        for (int phase = 0; phase < 3; phase++) begin
            wait_for_results();
            send_gap_pct   = gap_pcts[phase];
            recv_stall_pct = stall_pcts[phase];
            aw = $urandom_range(6, 32);
            ah = $urandom_range(6, 32);
            write_atlas(DIM_W'(aw), DIM_W'(ah));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                sel  = $urandom_range(0, 99);
                kind = KIND_PLACE;
                if (sel < 8) begin
                    kind = KIND_CLEAR;
                    rw   = DIM_W'($urandom_range(0, 8191));
                    rh   = DIM_W'($urandom_range(0, 8191));
                end else if (sel < 14) begin
                    // Malformed sizes: zero or larger than the atlas.
                    rw = DIM_W'($urandom_range(1, 8191));
                    rh = DIM_W'($urandom_range(1, 8191));
                    case ($urandom_range(0, 3))
                        0: rw = '0;
                        1: rh = '0;
                        2: rw = DIM_W'(aw + $urandom_range(1, 8191 - aw));
                        default: rh = DIM_W'(ah + $urandom_range(1, 8191 - ah));
                    endcase
                end else begin
                    rw = DIM_W'($urandom_range(1, (aw + 2) / 3));
                    rh = DIM_W'($urandom_range(1, (ah + 2) / 3));
                end
                send_request(kind, rw, rh, 1'b0, '0);
                // Now and then the sender holds off until the block has drained.
                if ($urandom_range(0, 29) == 0) begin
                    wait_for_results();
                end
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && placements_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: ends the run as failed after a time far above the slowest correct run.
    initial begin
        #100_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
